// ===== rtl/pbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbp_pkg;

  // Field and channel widths.
  localparam int unsigned ChanW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned BytesW = 3;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_BLEND_CONTROL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_COLOR  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_COLOR  = 2'd2;

  // Bit positions inside blend_control.
  localparam int unsigned BC_ACB_EN   = 3;
  localparam int unsigned BC_AS_ALPHA = 6;
  localparam int unsigned BC_AD_ALPHA = 7;
  localparam int unsigned BC_FMT_HI   = 8;
  localparam int unsigned BC_CS_ALPHA = 9;
  localparam int unsigned BC_CD_ALPHA = 10;
  localparam int unsigned BC_CS_INV   = 11;
  localparam int unsigned BC_CD_INV   = 12;
  localparam int unsigned BC_FMT_POS  = 20;
  localparam int unsigned BC_ASEL_POS = 22;
  localparam int unsigned BC_AS_INV   = 28;
  localparam int unsigned BC_AD_INV   = 29;

  // Full scale and rounding bias of the blend arithmetic.
  localparam logic [ChanW-1:0] FULL       = 8'd255;
  localparam logic [ChanW-1:0] ROUND_BIAS = 8'd127;
  // Smallest weighted sum whose quotient by 255 exceeds 255.
  localparam logic [16:0]      SAT_LIMIT  = 17'd65280;

  // Write formats.
  typedef enum logic [2:0] {
    FMT_A8       = 3'd0,
    FMT_RGB565   = 3'd1,
    FMT_ARGB8888 = 3'd2,
    FMT_ARGB4444 = 3'd3,
    FMT_RSVD4    = 3'd4,
    FMT_RSVD5    = 3'd5,
    FMT_RSVD6    = 3'd6,
    FMT_RSVD7    = 3'd7
  } pbp_fmt_t;

  // Output alpha source when the alpha blend is off.
  typedef enum logic [1:0] {
    ASEL_SECOND = 2'd0,
    ASEL_SOURCE = 2'd1,
    ASEL_ZERO   = 2'd2,
    ASEL_DEST   = 2'd3
  } pbp_asel_t;

  // Blend factor pair handed to one channel mixer.
  typedef struct packed {
    logic [ChanW-1:0] fs;
    logic [ChanW-1:0] fd;
  } pbp_factors_t;

  // Factor on a 0..255 scale: 255, alpha, 0 or 255 - alpha.
  function automatic logic [ChanW-1:0] blend_factor(input logic by_alpha,
                                                    input logic inv,
                                                    input logic [ChanW-1:0] a);
    logic [ChanW-1:0] f;
    if (by_alpha) begin
      f = inv ? (FULL - a) : a;
    end else begin
      f = inv ? '0 : FULL;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pixel_blend_and_pack_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                          Handshake
// in_       input      in_dest_pixel[31:0]              in_valid / in_stall
// out_      output     out_pixel[31:0], out_pixel_bytes out_valid / out_stall
// cfg_      input      cfg_index[1:0], cfg_data[31:0]   cfg_we (no wait)
//
// A pixel taken at the input is held in the input register and then in the
// result register, from which out_pixel is driven. One pixel is accepted
// every cycle while out_stall stays low.
// Reset is synchronous and clears the configuration and both valid flags.
// While the result register is held by out_stall, the input register still
// takes one more pixel; in_stall rises only when both are full.
module pixel_blend_and_pack_unit import pbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WordW-1:0]  in_dest_pixel,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WordW-1:0]       out_pixel,
  output logic [BytesW-1:0]      out_pixel_bytes,
  input  wire logic              cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WordW-1:0]  cfg_data
);

  logic [WordW-1:0]  blend_control_r;
  logic [WordW-1:0]  source_color_r;
  logic [WordW-1:0]  second_color_r;

  logic              in_valid_r;
  logic [WordW-1:0]  dest_r;
  logic              res_valid_r;
  logic [WordW-1:0]  res_pixel_r;
  logic [BytesW-1:0] res_bytes_r;

  logic              res_free;
  logic              in_take;
  logic              in_adv;

  logic [ChanW-1:0]  sa;
  logic [ChanW-1:0]  da;
  pbp_factors_t      col_fac;
  pbp_factors_t      alp_fac;
  logic [ChanW-1:0]  r_mix;
  logic [ChanW-1:0]  g_mix;
  logic [ChanW-1:0]  b_mix;
  logic [ChanW-1:0]  a_mix;
  logic [ChanW-1:0]  a_out;
  pbp_fmt_t          fmt;
  pbp_asel_t         asel;
  logic [WordW-1:0]  pixel_nxt;
  logic [BytesW-1:0] bytes_nxt;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_control_r <= '0;
      source_color_r  <= '0;
      second_color_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLEND_CONTROL: blend_control_r <= cfg_data;
        CFG_SOURCE_COLOR:  source_color_r  <= cfg_data;
        CFG_SECOND_COLOR:  second_color_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: the result register frees when empty or when taken.
  assign res_free = !res_valid_r || !out_stall;
  assign in_adv   = in_valid_r && res_free;
  assign in_stall = in_valid_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (in_adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      dest_r <= in_dest_pixel;
    end
  end

  // Blend factors for colour and alpha, all driven by the source alpha.
  assign sa = source_color_r[31:24];
  assign da = dest_r[31:24];

  assign col_fac.fs = blend_factor(blend_control_r[BC_CS_ALPHA],
                                   blend_control_r[BC_CS_INV], sa);
  assign col_fac.fd = blend_factor(blend_control_r[BC_CD_ALPHA],
                                   blend_control_r[BC_CD_INV], sa);
  assign alp_fac.fs = blend_factor(blend_control_r[BC_AS_ALPHA],
                                   blend_control_r[BC_AS_INV], sa);
  assign alp_fac.fd = blend_factor(blend_control_r[BC_AD_ALPHA],
                                   blend_control_r[BC_AD_INV], sa);

  // One mixer per channel.
  pbp_mix u_mix_r (
    .s   (source_color_r[23:16]),
    .d   (dest_r[23:16]),
    .fac (col_fac),
    .q   (r_mix)
  );

  pbp_mix u_mix_g (
    .s   (source_color_r[15:8]),
    .d   (dest_r[15:8]),
    .fac (col_fac),
    .q   (g_mix)
  );

  pbp_mix u_mix_b (
    .s   (source_color_r[7:0]),
    .d   (dest_r[7:0]),
    .fac (col_fac),
    .q   (b_mix)
  );

  pbp_mix u_mix_a (
    .s   (sa),
    .d   (da),
    .fac (alp_fac),
    .q   (a_mix)
  );

  // Output alpha: blended, or picked by the alpha source code.
  assign asel = pbp_asel_t'(blend_control_r[BC_ASEL_POS +: 2]);

  always_comb begin
    if (blend_control_r[BC_ACB_EN]) begin
      a_out = a_mix;
    end else begin
      unique case (asel)
        ASEL_SECOND: a_out = second_color_r[31:24];
        ASEL_SOURCE: a_out = sa;
        ASEL_ZERO:   a_out = '0;
        ASEL_DEST:   a_out = da;
        default:     a_out = '0;
      endcase
    end
  end

  // Packing to the write format; reserved codes pass ARGB8888 through.
  assign fmt = pbp_fmt_t'({blend_control_r[BC_FMT_HI],
                           blend_control_r[BC_FMT_POS +: 2]});

  always_comb begin
    unique case (fmt)
      FMT_A8: begin
        pixel_nxt = {24'd0, a_out};
        bytes_nxt = 3'd1;
      end
      FMT_RGB565: begin
        pixel_nxt = {16'd0, r_mix[7:3], g_mix[7:2], b_mix[7:3]};
        bytes_nxt = 3'd2;
      end
      FMT_ARGB4444: begin
        pixel_nxt = {16'd0, a_out[7:4], r_mix[7:4], g_mix[7:4], b_mix[7:4]};
        bytes_nxt = 3'd2;
      end
      default: begin
        pixel_nxt = {a_out, r_mix, g_mix, b_mix};
        bytes_nxt = 3'd4;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      res_pixel_r <= pixel_nxt;
      res_bytes_r <= bytes_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_pixel       = res_pixel_r;
  assign out_pixel_bytes = res_bytes_r;

endmodule

`default_nettype wire

// ===== rtl/pbp_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One channel of the blend: (s*fs + d*fd + 127) / 255, saturated at 255.
module pbp_mix import pbp_pkg::*; (
  input  wire logic [ChanW-1:0] s,
  input  wire logic [ChanW-1:0] d,
  input  wire pbp_factors_t     fac,
  output logic      [ChanW-1:0] q
);

  logic [15:0] prod_s;
  logic [15:0] prod_d;
  logic [16:0] sum;
  logic [16:0] recip;

  // Weighted sum with rounding bias; fits in 17 bits.
  assign prod_s = s * fac.fs;
  assign prod_d = d * fac.fd;
  assign sum    = {1'b0, prod_s} + {1'b0, prod_d} + {9'd0, ROUND_BIAS};

  // Exact division by 255 for sums below 255*256: (x + (x >> 8) + 1) >> 8.
  assign recip = {1'b0, sum[15:0]} + {9'd0, sum[15:8]} + 17'd1;

  // Sums at or above the limit would give more than 255, so clamp.
  assign q = (sum >= SAT_LIMIT) ? FULL : recip[15:8];

endmodule

`default_nettype wire
